// ----- src/plar_pkg.sv -----
// ----------------------------------------------------------------------------
// plar_pkg
// shared types, constants and command/status structs of the resampler
// ----------------------------------------------------------------------------
package plar_pkg;

   localparam int MAX_POINTS   = 8192;
   localparam int MAX_PER_ITEM = 64;

   localparam int CNT_W  = $clog2(MAX_POINTS);
   localparam int K_W    = $clog2(MAX_PER_ITEM + 1);
   localparam int STEP_W = 6;

   localparam logic [31:0]      SPACING_RESET = 32'd65536;
   localparam logic [CNT_W-1:0] CNT_LIMIT     = CNT_W'(MAX_POINTS - 1);
   localparam logic [CNT_W-1:0] CNT_ONE       = CNT_W'(1);
   localparam logic [K_W-1:0]   CAP_MID       = K_W'(MAX_PER_ITEM);
   localparam logic [K_W-1:0]   CAP_LAST      = K_W'(MAX_PER_ITEM - 1);
   localparam logic [47:0]      LEN_MAX       = '1;

   localparam logic [STEP_W-1:0] SQRT_STEPS     = STEP_W'(33);
   localparam logic [STEP_W-1:0] DIV_INT_STEPS  = STEP_W'(35);
   localparam logic [STEP_W-1:0] DIV_FRAC_STEPS = STEP_W'(32);

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic               last_vertex;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] qx;
      logic signed [31:0] qy;
      logic signed [31:0] qz;
      logic               run_end;
      logic               line_done;
      logic [47:0]        total_length;
      logic               overflow;
      logic               truncated;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      AX_X,
      AX_Y,
      AX_Z
   } axis_type;

   typedef enum logic [1:0] {
      OUT_FIRST,
      OUT_POINT,
      OUT_END
   } out_kind_type;

   typedef struct packed {
      logic         capture;
      logic         first_init;
      logic         diff_load;
      logic         mul_en;
      logic         mul_interp;
      axis_type     mul_axis;
      logic         acc_clear;
      logic         acc_add;
      logic         wr_en;
      axis_type     wr_axis;
      logic         sqrt_start;
      logic         seg_load;
      logic         sum_load;
      logic         div_start;
      logic         quot_load;
      logic         step_load;
      logic         fact_start;
      logic         fact_sat;
      logic         fact_load;
      logic         out_load;
      out_kind_type out_kind;
      logic         line_clear;
   } plar_cmd_type;

   typedef struct packed {
      logic expect_first;
      logic last;
      logic sqrt_done;
      logic div_done;
      logic fact_direct;
      logic more_points;
   } plar_status_type;

endpackage

// ----- src/polyline_arclength_resampler.sv -----
// ----------------------------------------------------------------------------
// polyline_arclength_resampler
// emits points a fixed arc length apart along a 3D polyline, Q15.16
// ----------------------------------------------------------------------------
// One vertex is handled at a time; req_stall is high from acceptance until
// its last point has been placed in the output register. A first vertex
// needs no length work. A later vertex waits on the square root and the
// integer divide for the point count, then for each emitted point on the
// fraction divide, where needed, and the shared multiplier used once per
// axis. Output stalls add to the time a vertex takes.
module polyline_arclength_resampler (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  plar_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output plar_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_we,
   input  logic [31:0]               csr_wdata
);
   import plar_pkg::*;

   plar_cmd_type    cmd;
   plar_status_type status;

   plar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   plar_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // endpoint always closes the run of its vertex
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_done |-> rsp_data.run_end)
      else $error("endpoint without run_end");

   // length only reported on the endpoint
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.line_done |-> rsp_data.total_length == '0)
      else $error("total_length on non-endpoint transaction");

   // ready for a vertex straight after reset
   assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("stall after reset");
`endif

endmodule

// ----- src/plar_sqrt.sv -----
// ----------------------------------------------------------------------------
// plar_sqrt
// digit-by-digit integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module plar_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] radicand,
   output logic        done,
   output logic [33:0] root
);
   import plar_pkg::*;

   logic [65:0]       n_ff, n_in;
   logic [35:0]       r_ff, r_in;
   logic [32:0]       q_ff, q_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [37:0]       shifted;
   logic [37:0]       trial;

   always_comb begin
      shifted = {r_ff, n_ff[65:64]};
      trial   = {3'b000, q_ff, 2'b01};
      n_in    = n_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         n_in    = radicand;
         r_in    = '0;
         q_in    = '0;
         cnt_in  = SQRT_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         n_in   = {n_ff[63:0], 2'b00};
         cnt_in = cnt_ff - STEP_W'(1);
         if (shifted >= trial) begin
            r_in = 36'(shifted - trial);
            q_in = {q_ff[31:0], 1'b1};
         end else begin
            r_in = shifted[35:0];
            q_in = {q_ff[31:0], 1'b0};
         end
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = {1'b0, q_ff};

endmodule

// ----- src/plar_div.sv -----
// ----------------------------------------------------------------------------
// plar_div
// restoring divider, one quotient bit per cycle, integer or fraction mode
// ----------------------------------------------------------------------------
module plar_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [33:0]               rem_init,
   input  logic [34:0]               dividend,
   input  logic [33:0]               divisor,
   input  logic [plar_pkg::STEP_W-1:0] steps,
   output logic                      done,
   output logic [34:0]               quotient,
   output logic [33:0]               remainder
);
   import plar_pkg::*;

   logic [34:0]       r_ff, r_in;
   logic [34:0]       d_ff, d_in;
   logic [34:0]       q_ff, q_in;
   logic [33:0]       dv_ff, dv_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [35:0]       shifted;

   always_comb begin
      shifted = {r_ff, d_ff[34]};
      r_in    = r_ff;
      d_in    = d_ff;
      q_in    = q_ff;
      dv_in   = dv_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         r_in    = {1'b0, rem_init};
         d_in    = dividend;
         q_in    = '0;
         dv_in   = divisor;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         d_in   = {d_ff[33:0], 1'b0};
         cnt_in = cnt_ff - STEP_W'(1);
         if (shifted >= {2'b00, dv_ff}) begin
            r_in = 35'(shifted - {2'b00, dv_ff});
            q_in = {q_ff[33:0], 1'b1};
         end else begin
            r_in = shifted[34:0];
            q_in = {q_ff[33:0], 1'b0};
         end
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      dv_ff  <= dv_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff[33:0];

endmodule

// ----- src/plar_dpath.sv -----
// ----------------------------------------------------------------------------
// plar_dpath
// vertex registers, shared multiplier, sqrt and divider units, result register
// ----------------------------------------------------------------------------
module plar_dpath (
   input  logic                      clock,
   input  logic                      reset,
   input  plar_pkg::plar_cmd_type    cmd,
   output plar_pkg::plar_status_type status,
   input  plar_pkg::req_payload_type req_data,
   input  logic                      csr_we,
   input  logic [31:0]               csr_wdata,
   output plar_pkg::rsp_payload_type rsp_data
);
   import plar_pkg::*;

   logic [31:0]        spacing_ff;
   logic [31:0]        sp;
   logic signed [31:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic signed [31:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic               last_ff;
   logic signed [32:0] dx_ff, dy_ff, dz_ff;
   logic [65:0]        prod_ff;
   logic [65:0]        acc_ff;
   logic [33:0]        seg_ff;
   logic [34:0]        t_ff;
   logic [33:0]        rem_ff;
   logic [47:0]        len_ff;
   logic               first_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [K_W-1:0]     k_ff, m_ff;
   logic               trunc_ff;
   logic [32:0]        f_ff;
   logic signed [31:0] ix_ff, iy_ff, iz_ff;
   rsp_payload_type    rsp_ff, rsp_in;

   logic signed [32:0] mul_d, wr_d;
   logic signed [31:0] wr_cur, wr_val;
   logic [32:0]        op_a, op_b;
   logic [65:0]        rounded;
   logic [31:0]        off;
   logic [48:0]        len_sum;
   logic [34:0]        div_dividend;
   logic               div_go;
   logic [33:0]        div_rinit;
   logic [34:0]        div_num;
   logic [33:0]        div_den;
   logic [STEP_W-1:0]  div_steps;
   logic               div_done, sqrt_done;
   logic [34:0]        quot;
   logic [33:0]        div_rem;
   logic [33:0]        root;
   logic [K_W-1:0]     cap;
   logic               n_over;
   logic [CNT_W-1:0]   cnt_inc;

   assign sp = (spacing_ff == 32'd0) ? 32'd1 : spacing_ff;

   always_comb begin
      case (cmd.mul_axis)
         AX_Y:    mul_d = dy_ff;
         AX_Z:    mul_d = dz_ff;
         default: mul_d = dx_ff;
      endcase
      case (cmd.wr_axis)
         AX_Y: begin
            wr_d   = dy_ff;
            wr_cur = cur_y_ff;
         end
         AX_Z: begin
            wr_d   = dz_ff;
            wr_cur = cur_z_ff;
         end
         default: begin
            wr_d   = dx_ff;
            wr_cur = cur_x_ff;
         end
      endcase
   end

   assign op_a    = mul_d[32] ? 33'(-mul_d) : 33'(mul_d);
   assign op_b    = cmd.mul_interp ? f_ff : op_a;
   assign rounded = prod_ff + 66'h0_8000_0000;
   assign off     = rounded[63:32];
   assign wr_val  = wr_d[32] ? 32'(wr_cur + off) : 32'(wr_cur - off);

   assign len_sum = {1'b0, len_ff} + 49'(seg_ff);

   always_comb begin
      if (last_ff) begin
         div_dividend = t_ff;
      end else if (t_ff == 35'd0) begin
         div_dividend = '0;
      end else begin
         div_dividend = t_ff - 35'd1;
      end
      div_go    = cmd.div_start | cmd.fact_start;
      div_rinit = cmd.fact_start ? t_ff[33:0] : 34'd0;
      div_num   = cmd.fact_start ? 35'd0 : div_dividend;
      div_den   = cmd.fact_start ? seg_ff : {2'b00, sp};
      div_steps = cmd.fact_start ? DIV_FRAC_STEPS : DIV_INT_STEPS;
   end

   plar_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (acc_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   plar_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go),
      .rem_init  (div_rinit),
      .dividend  (div_num),
      .divisor   (div_den),
      .steps     (div_steps),
      .done      (div_done),
      .quotient  (quot),
      .remainder (div_rem)
   );

   assign cap     = last_ff ? CAP_LAST : CAP_MID;
   assign n_over  = quot > 35'(cap);
   assign cnt_inc = cnt_ff + CNT_ONE;

   always_comb begin
      rsp_in = rsp_ff;
      case (cmd.out_kind)
         OUT_POINT: begin
            rsp_in.qx           = ix_ff;
            rsp_in.qy           = iy_ff;
            rsp_in.qz           = iz_ff;
            rsp_in.run_end      = !last_ff && ((k_ff == m_ff) || (cnt_inc >= CNT_LIMIT));
            rsp_in.line_done    = 1'b0;
            rsp_in.total_length = '0;
            rsp_in.overflow     = cnt_inc >= CNT_LIMIT;
            rsp_in.truncated    = trunc_ff;
         end
         OUT_END: begin
            rsp_in.qx           = cur_x_ff;
            rsp_in.qy           = cur_y_ff;
            rsp_in.qz           = cur_z_ff;
            rsp_in.run_end      = 1'b1;
            rsp_in.line_done    = 1'b1;
            rsp_in.total_length = len_ff;
            rsp_in.overflow     = cnt_ff >= CNT_LIMIT;
            rsp_in.truncated    = trunc_ff;
         end
         default: begin
            rsp_in.qx           = cur_x_ff;
            rsp_in.qy           = cur_y_ff;
            rsp_in.qz           = cur_z_ff;
            rsp_in.run_end      = !last_ff;
            rsp_in.line_done    = 1'b0;
            rsp_in.total_length = '0;
            rsp_in.overflow     = CNT_ONE >= CNT_LIMIT;
            rsp_in.truncated    = 1'b0;
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_x_ff <= req_data.px;
         cur_y_ff <= req_data.py;
         cur_z_ff <= req_data.pz;
         last_ff  <= req_data.last_vertex;
      end
      if (cmd.diff_load) begin
         dx_ff <= 33'(cur_x_ff) - 33'(prev_x_ff);
         dy_ff <= 33'(cur_y_ff) - 33'(prev_y_ff);
         dz_ff <= 33'(cur_z_ff) - 33'(prev_z_ff);
      end
      if (cmd.mul_en) begin
         prod_ff <= 66'(op_a) * 66'(op_b);
      end
      if (cmd.acc_clear) begin
         acc_ff <= prod_ff;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (cmd.seg_load) begin
         seg_ff <= root;
      end
      if (cmd.sum_load) begin
         t_ff <= {1'b0, rem_ff} + {1'b0, seg_ff};
      end else if (cmd.step_load) begin
         t_ff <= t_ff - 35'(sp);
      end
      if (cmd.quot_load) begin
         m_ff <= n_over ? cap : quot[K_W-1:0];
         k_ff <= '0;
      end else if (cmd.step_load) begin
         k_ff <= k_ff + K_W'(1);
      end
      if (cmd.fact_sat) begin
         f_ff <= (seg_ff == 34'd0) ? 33'd0 : 33'h1_0000_0000;
      end else if (cmd.fact_load) begin
         f_ff <= {1'b0, quot[31:0]};
      end
      if (cmd.wr_en) begin
         case (cmd.wr_axis)
            AX_Y:    iy_ff <= wr_val;
            AX_Z:    iz_ff <= wr_val;
            default: ix_ff <= wr_val;
         endcase
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // line state
   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SPACING_RESET;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         prev_z_ff  <= '0;
         rem_ff     <= '0;
         len_ff     <= '0;
         first_ff   <= 1'b1;
         cnt_ff     <= '0;
         trunc_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            spacing_ff <= csr_wdata;
         end
         if (cmd.diff_load || cmd.first_init) begin
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
            prev_z_ff <= cur_z_ff;
         end
         if (cmd.line_clear) begin
            rem_ff   <= '0;
            len_ff   <= '0;
            first_ff <= 1'b1;
            cnt_ff   <= '0;
         end else if (cmd.first_init) begin
            rem_ff   <= '0;
            len_ff   <= '0;
            first_ff <= 1'b0;
            cnt_ff   <= CNT_ONE;
            trunc_ff <= 1'b0;
         end else begin
            if (cmd.sum_load) begin
               len_ff <= len_sum[48] ? LEN_MAX : len_sum[47:0];
            end
            if (cmd.quot_load) begin
               trunc_ff <= n_over;
               if (last_ff || t_ff == 35'd0) begin
                  rem_ff <= '0;
               end else begin
                  rem_ff <= div_rem + 34'd1;
               end
            end
            if (cmd.out_load && cmd.out_kind == OUT_POINT) begin
               cnt_ff <= cnt_inc;
            end
         end
      end
   end

   assign status.expect_first = first_ff;
   assign status.last         = last_ff;
   assign status.sqrt_done    = sqrt_done;
   assign status.div_done     = div_done;
   assign status.fact_direct  = (seg_ff == 34'd0) || (t_ff >= {1'b0, seg_ff});
   assign status.more_points  = (k_ff < m_ff) && (cnt_ff < CNT_LIMIT);

   assign rsp_data = rsp_ff;

endmodule

// ----- src/plar_ctrl.sv -----
// ----------------------------------------------------------------------------
// plar_ctrl
// sequencer for one vertex: length, point count, per-point interpolation
// ----------------------------------------------------------------------------
module plar_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output plar_pkg::plar_cmd_type    cmd,
   input  plar_pkg::plar_status_type status
);
   import plar_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FIRST,
      ST_DIFF,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQ_ACC,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_SUM,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_PT_CHECK,
      ST_FACT,
      ST_FACT_WAIT,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_Z,
      ST_WR_Z,
      ST_PT_EMIT,
      ST_END
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = status.expect_first ? ST_FIRST : ST_DIFF;
            end
         end
         ST_FIRST: begin
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_kind   = OUT_FIRST;
               cmd.first_init = 1'b1;
               state_in       = status.last ? ST_END : ST_IDLE;
            end
         end
         ST_DIFF: begin
            cmd.diff_load = 1'b1;
            state_in      = ST_SQ_X;
         end
         ST_SQ_X: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_axis = AX_X;
            state_in     = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_axis  = AX_Y;
            cmd.acc_clear = 1'b1;
            state_in      = ST_SQ_Z;
         end
         ST_SQ_Z: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_axis = AX_Z;
            cmd.acc_add  = 1'b1;
            state_in     = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               cmd.seg_load = 1'b1;
               state_in     = ST_SUM;
            end
         end
         ST_SUM: begin
            cmd.sum_load = 1'b1;
            state_in     = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.quot_load = 1'b1;
               state_in      = ST_PT_CHECK;
            end
         end
         ST_PT_CHECK: begin
            if (status.more_points) begin
               cmd.step_load = 1'b1;
               state_in      = ST_FACT;
            end else begin
               state_in = status.last ? ST_END : ST_IDLE;
            end
         end
         ST_FACT: begin
            if (status.fact_direct) begin
               cmd.fact_sat = 1'b1;
               state_in     = ST_MUL_X;
            end else begin
               cmd.fact_start = 1'b1;
               state_in       = ST_FACT_WAIT;
            end
         end
         ST_FACT_WAIT: begin
            if (status.div_done) begin
               cmd.fact_load = 1'b1;
               state_in      = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_interp = 1'b1;
            cmd.mul_axis   = AX_X;
            state_in       = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_interp = 1'b1;
            cmd.mul_axis   = AX_Y;
            cmd.wr_en      = 1'b1;
            cmd.wr_axis    = AX_X;
            state_in       = ST_MUL_Z;
         end
         ST_MUL_Z: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_interp = 1'b1;
            cmd.mul_axis   = AX_Z;
            cmd.wr_en      = 1'b1;
            cmd.wr_axis    = AX_Y;
            state_in       = ST_WR_Z;
         end
         ST_WR_Z: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_axis = AX_Z;
            state_in    = ST_PT_EMIT;
         end
         ST_PT_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_POINT;
               state_in     = ST_PT_CHECK;
            end
         end
         ST_END: begin
            if (out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_kind   = OUT_END;
               cmd.line_clear = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
